>>> src/gbnq_pkg.sv
package gbnq_pkg;

  localparam int OP_W       = 2;
  localparam int ID_W       = 10;
  localparam int POS_W      = 16;
  localparam int ST_W       = 3;
  localparam int FILL_W     = 3;
  localparam int COORD_W    = 12;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;
  localparam int ENTRY_W    = ID_W + 2 * POS_W;

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_QUERY  = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

  localparam logic [ST_W-1:0] ST_STORED   = 3'd0;
  localparam logic [ST_W-1:0] ST_FULL     = 3'd1;
  localparam logic [ST_W-1:0] ST_OUTSIDE  = 3'd2;
  localparam logic [ST_W-1:0] ST_NEIGHBOR = 3'd3;
  localparam logic [ST_W-1:0] ST_NONE     = 3'd4;
  localparam logic [ST_W-1:0] ST_CLEARED  = 3'd5;

  localparam logic [CFG_IDX_W-1:0] REG_CELL_SIZE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLUMNS   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS      = 2'd2;

  typedef struct packed {
    logic            ready;
    logic            capture;
    logic            div_step;
    logic            clr_step;
    logic            ins_cell;
    logic            ins_base;
    logic            ins_commit;
    logic            nb_cell;
    logic            nb_adv;
    logic            fill_take;
    logic            ent_addr;
    logic            ent_take;
    logic            emit;
    logic            emit_pend;
    logic            emit_last;
    logic [ST_W-1:0] emit_status;
  } cmd_t;

  typedef struct packed {
    logic            accept;
    logic [OP_W-1:0] op;
    logic            div_last;
    logic            sweep_last;
    logic            oob;
    logic            full;
    logic            nb_end;
    logic            nb_in;
    logic            ent_end;
    logic            pend_valid;
    logic            out_free;
  } stat_t;

endpackage

>>> src/gbnq_if.sv
interface gbnq_req_if;
  logic                          valid;
  logic                          ready;
  logic [gbnq_pkg::OP_W-1:0]     operation;
  logic [gbnq_pkg::ID_W-1:0]     item_id;
  logic [gbnq_pkg::POS_W-1:0]    pos_x;
  logic [gbnq_pkg::POS_W-1:0]    pos_y;
  modport source (output valid, operation, item_id, pos_x, pos_y, input ready);
  modport sink (input valid, operation, item_id, pos_x, pos_y, output ready);
endinterface

interface gbnq_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [gbnq_pkg::ST_W-1:0]     status;
  logic [gbnq_pkg::ID_W-1:0]     neighbor_id;
  logic [gbnq_pkg::POS_W-1:0]    neighbor_x;
  logic [gbnq_pkg::POS_W-1:0]    neighbor_y;
  logic                          last;
  modport source (output valid, status, neighbor_id, neighbor_x, neighbor_y, last,
                  input ready);
  modport sink (input valid, status, neighbor_id, neighbor_x, neighbor_y, last,
                output ready);
endinterface

interface gbnq_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [gbnq_pkg::CFG_IDX_W-1:0]  index;
  logic [gbnq_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> src/grid_bucket_neighbor_query.sv
// Uniform grid of point buckets with a 3x3 neighbor query.
// Words enter on req: operation, item_id, pos_x, pos_y. Results leave on rsp:
// status, neighbor_id, neighbor_x, neighbor_y and last, which marks the final
// result word of each request. Registers are written on cfg (index 0 cell size,
// 1 column count, 2 row count); the user must write them only while the
// block is idle, which the block itself does not enforce. One request is
// worked at a time. The cell coordinates come from a 12-step restoring
// divider. A clear sweeps the count memory one cell per cycle and then gives
// its result. After reset the same sweep runs with req held not ready;
// registers return to 32, 32, 32.
// A result word sits in an output register; while the receiver stalls, the
// block finishes its current step and waits, and req is taken again once the
// block is back to idle, even while the last word still waits to be taken.
module grid_bucket_neighbor_query #(
  parameter int CELL_CAPACITY = 4,
  parameter int MAX_COLUMNS   = 32,
  parameter int MAX_ROWS      = 32
) (
  input logic        clk,
  input logic        rst,
  gbnq_req_if.sink   req,
  gbnq_rsp_if.source rsp,
  gbnq_cfg_if.sink   cfg
);
  import gbnq_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  gbnq_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .cmd  (cmd)
  );

  gbnq_dp #(
    .CELL_CAPACITY (CELL_CAPACITY),
    .MAX_COLUMNS   (MAX_COLUMNS),
    .MAX_ROWS      (MAX_ROWS)
  ) u_dp (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .rsp  (rsp),
    .cfg  (cfg),
    .cmd  (cmd),
    .stat (stat)
  );
endmodule

>>> src/gbnq_ram.sv
module gbnq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> src/gbnq_ctrl.sv
module gbnq_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  gbnq_pkg::stat_t stat,
  output gbnq_pkg::cmd_t  cmd
);
  import gbnq_pkg::*;

  localparam logic [3:0] S_RCLR  = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_DIV   = 4'd2;
  localparam logic [3:0] S_ICELL = 4'd3;
  localparam logic [3:0] S_IW    = 4'd4;
  localparam logic [3:0] S_IFILL = 4'd5;
  localparam logic [3:0] S_IWR   = 4'd6;
  localparam logic [3:0] S_EMIT  = 4'd7;
  localparam logic [3:0] S_OCLR  = 4'd8;
  localparam logic [3:0] S_QNB   = 4'd9;
  localparam logic [3:0] S_QW    = 4'd10;
  localparam logic [3:0] S_QF    = 4'd11;
  localparam logic [3:0] S_QE    = 4'd12;
  localparam logic [3:0] S_QEW   = 4'd13;
  localparam logic [3:0] S_QED   = 4'd14;
  localparam logic [3:0] S_QEND  = 4'd15;

  logic [3:0]      state, state_next;
  logic [ST_W-1:0] code, code_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_RCLR;
      code  <= ST_STORED;
    end else begin
      state <= state_next;
      code  <= code_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    code_next  = code;
    unique case (state)
      S_RCLR: begin
        cmd.clr_step = 1'b1;
        if (stat.sweep_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        cmd.ready = 1'b1;
        if (stat.accept) begin
          cmd.capture = 1'b1;
          if (stat.op == OP_INSERT || stat.op == OP_QUERY) state_next = S_DIV;
          else if (stat.op == OP_CLEAR) state_next = S_OCLR;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) state_next = (stat.op == OP_INSERT) ? S_ICELL : S_QNB;
      end
      S_ICELL: begin
        if (stat.oob) begin
          code_next  = ST_OUTSIDE;
          state_next = S_EMIT;
        end else begin
          cmd.ins_cell = 1'b1;
          state_next   = S_IW;
        end
      end
      S_IW: state_next = S_IFILL;
      S_IFILL: begin
        if (stat.full) begin
          code_next  = ST_FULL;
          state_next = S_EMIT;
        end else begin
          cmd.ins_base = 1'b1;
          state_next   = S_IWR;
        end
      end
      S_IWR: begin
        cmd.ins_commit = 1'b1;
        code_next      = ST_STORED;
        state_next     = S_EMIT;
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.emit        = 1'b1;
          cmd.emit_last   = 1'b1;
          cmd.emit_status = code;
          state_next      = S_IDLE;
        end
      end
      S_OCLR: begin
        cmd.clr_step = 1'b1;
        if (stat.sweep_last) begin
          code_next  = ST_CLEARED;
          state_next = S_EMIT;
        end
      end
      S_QNB: begin
        if (stat.nb_end) begin
          state_next = S_QEND;
        end else if (stat.nb_in) begin
          cmd.nb_cell = 1'b1;
          state_next  = S_QW;
        end else begin
          cmd.nb_adv = 1'b1;
        end
      end
      S_QW: state_next = S_QF;
      S_QF: begin
        cmd.fill_take = 1'b1;
        state_next    = S_QE;
      end
      S_QE: begin
        if (stat.ent_end) begin
          cmd.nb_adv = 1'b1;
          state_next = S_QNB;
        end else begin
          cmd.ent_addr = 1'b1;
          state_next   = S_QEW;
        end
      end
      S_QEW: state_next = S_QED;
      S_QED: begin
        if (!stat.pend_valid || stat.out_free) begin
          cmd.ent_take  = 1'b1;
          cmd.emit      = stat.pend_valid;
          cmd.emit_pend = 1'b1;
          state_next    = S_QE;
        end
      end
      S_QEND: begin
        if (stat.out_free) begin
          cmd.emit        = 1'b1;
          cmd.emit_pend   = stat.pend_valid;
          cmd.emit_last   = 1'b1;
          cmd.emit_status = ST_NONE;
          state_next      = S_IDLE;
        end
      end
      default: state_next = S_RCLR;
    endcase
  end
endmodule

>>> src/gbnq_dp.sv
module gbnq_dp #(
  parameter int CELL_CAPACITY = 4,
  parameter int MAX_COLUMNS   = 32,
  parameter int MAX_ROWS      = 32
) (
  input  logic            clk,
  input  logic            rst,
  gbnq_req_if.sink        req,
  gbnq_rsp_if.source      rsp,
  gbnq_cfg_if.sink        cfg,
  input  gbnq_pkg::cmd_t  cmd,
  output gbnq_pkg::stat_t stat
);
  import gbnq_pkg::*;

  localparam int NCELLS = MAX_COLUMNS * MAX_ROWS;
  localparam int NSLOTS = NCELLS * CELL_CAPACITY;
  localparam int CELL_W = $clog2(NCELLS);
  localparam int BKT_W  = $clog2(NSLOTS);
  localparam int EXT_W  = COORD_W + 1;
  localparam logic [8:0]        MAXC9 = 9'(MAX_COLUMNS);
  localparam logic [8:0]        MAXR9 = 9'(MAX_ROWS);
  localparam logic [FILL_W-1:0] CAP   = FILL_W'(CELL_CAPACITY);

  logic [CFG_DATA_W-1:0] cell_size;
  logic [5:0]            grid_columns, grid_rows;
  logic [8:0]            cols, rows;

  logic [OP_W-1:0]  op;
  logic [ID_W-1:0]  id;
  logic [POS_W-1:0] px, py;

  logic [COORD_W-1:0] dqx, dqy, rx, ry, dsor;
  logic [EXT_W-1:0]   ax, ay, dext;
  logic [3:0]         div_cnt;

  logic [1:0]         di, dj;
  logic [EXT_W-1:0]   tx, ty;
  logic [CELL_W-1:0]  cur_cell, sweep, ins_cell, nb_cell;
  logic [BKT_W-1:0]   baddr;
  logic [FILL_W-1:0]  fcount, ent, fill_q, fill_clamp;
  logic [ENTRY_W-1:0] bkt_q, pend;
  logic               pend_valid;
  logic               out_valid;
  logic               fill_we;
  logic [CELL_W-1:0]  fill_wa;
  logic [FILL_W-1:0]  fill_wd;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cell_size    <= 12'd32;
      grid_columns <= 6'd32;
      grid_rows    <= 6'd32;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_CELL_SIZE: cell_size    <= cfg.data;
        REG_COLUMNS:   grid_columns <= cfg.data[5:0];
        REG_ROWS:      grid_rows    <= cfg.data[5:0];
        default: ;
      endcase
    end
  end

  assign cols = ({3'b0, grid_columns} > MAXC9) ? MAXC9 : {3'b0, grid_columns};
  assign rows = ({3'b0, grid_rows} > MAXR9) ? MAXR9 : {3'b0, grid_rows};

  assign dsor = (cell_size == '0) ? COORD_W'(1) : cell_size;
  assign dext = {1'b0, dsor};
  assign ax   = {rx, dqx[COORD_W-1]};
  assign ay   = {ry, dqy[COORD_W-1]};

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op      <= req.operation;
      id      <= req.item_id;
      px      <= req.pos_x;
      py      <= req.pos_y;
      dqx     <= req.pos_x[POS_W-1:4];
      dqy     <= req.pos_y[POS_W-1:4];
      rx      <= '0;
      ry      <= '0;
      div_cnt <= '0;
    end else if (cmd.div_step) begin
      div_cnt <= div_cnt + 4'd1;
      if (ax >= dext) begin
        rx  <= COORD_W'(ax - dext);
        dqx <= {dqx[COORD_W-2:0], 1'b1};
      end else begin
        rx  <= ax[COORD_W-1:0];
        dqx <= {dqx[COORD_W-2:0], 1'b0};
      end
      if (ay >= dext) begin
        ry  <= COORD_W'(ay - dext);
        dqy <= {dqy[COORD_W-2:0], 1'b1};
      end else begin
        ry  <= ay[COORD_W-1:0];
        dqy <= {dqy[COORD_W-2:0], 1'b0};
      end
    end
  end

  assign tx = {1'b0, dqx} + EXT_W'(di);
  assign ty = {1'b0, dqy} + EXT_W'(dj);
  assign ins_cell = CELL_W'(32'(dqy) * MAX_COLUMNS + 32'(dqx));
  assign nb_cell  = CELL_W'((32'(ty) - 32'd1) * MAX_COLUMNS + 32'(tx) - 32'd1);

  always_ff @(posedge clk) begin
    if (rst) begin
      sweep <= '0;
    end else if (cmd.clr_step) begin
      sweep <= (sweep == CELL_W'(NCELLS - 1)) ? '0 : sweep + CELL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      di <= '0;
      dj <= '0;
    end else if (cmd.nb_adv) begin
      if (dj == 2'd2) begin
        dj <= '0;
        di <= di + 2'd1;
      end else begin
        dj <= dj + 2'd1;
      end
    end
    if (cmd.ins_cell) cur_cell <= ins_cell;
    else if (cmd.nb_cell) cur_cell <= nb_cell;
    if (cmd.ins_base) begin
      baddr  <= BKT_W'(32'(cur_cell) * CELL_CAPACITY + 32'(fill_q));
      fcount <= fill_q;
    end else if (cmd.ent_addr) begin
      baddr <= BKT_W'(32'(cur_cell) * CELL_CAPACITY + 32'(ent));
    end
    if (cmd.fill_take) begin
      fcount <= fill_clamp;
      ent    <= '0;
    end else if (cmd.ent_take) begin
      ent <= ent + FILL_W'(1);
    end
    if (cmd.ent_take) pend <= bkt_q;
  end

  assign fill_clamp = (fill_q > CAP) ? CAP : fill_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (cmd.capture) begin
      pend_valid <= 1'b0;
    end else if (cmd.ent_take) begin
      pend_valid <= 1'b1;
    end
  end

  assign fill_we = cmd.clr_step | cmd.ins_commit;
  assign fill_wa = cmd.clr_step ? sweep : cur_cell;
  assign fill_wd = cmd.clr_step ? '0 : fcount + FILL_W'(1);

  gbnq_ram #(.WIDTH(FILL_W), .DEPTH(NCELLS)) u_fill (
    .clk   (clk),
    .we    (fill_we),
    .waddr (fill_wa),
    .wdata (fill_wd),
    .raddr (cur_cell),
    .rdata (fill_q)
  );

  gbnq_ram #(.WIDTH(ENTRY_W), .DEPTH(NSLOTS)) u_bucket (
    .clk   (clk),
    .we    (cmd.ins_commit),
    .waddr (baddr),
    .wdata ({id, px, py}),
    .raddr (baddr),
    .rdata (bkt_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      rsp.last <= cmd.emit_last;
      if (cmd.emit_pend) begin
        rsp.status      <= ST_NEIGHBOR;
        rsp.neighbor_id <= pend[ENTRY_W-1 -: ID_W];
        rsp.neighbor_x  <= pend[2*POS_W-1 -: POS_W];
        rsp.neighbor_y  <= pend[POS_W-1:0];
      end else begin
        rsp.status      <= cmd.emit_status;
        rsp.neighbor_id <= '0;
        rsp.neighbor_x  <= '0;
        rsp.neighbor_y  <= '0;
      end
    end
  end

  assign rsp.valid = out_valid;
  assign req.ready = cmd.ready;

  assign stat.accept     = req.valid & cmd.ready;
  assign stat.op         = cmd.ready ? req.operation : op;
  assign stat.div_last   = (div_cnt == 4'(COORD_W - 1));
  assign stat.sweep_last = (sweep == CELL_W'(NCELLS - 1));
  assign stat.oob        = ({1'b0, dqx} >= EXT_W'(cols)) || ({1'b0, dqy} >= EXT_W'(rows));
  assign stat.full       = (fill_q >= CAP);
  assign stat.nb_end     = (di == 2'd3);
  assign stat.nb_in      = (tx != '0) && (tx <= EXT_W'(cols)) &&
                           (ty != '0) && (ty <= EXT_W'(rows));
  assign stat.ent_end    = (ent >= fcount);
  assign stat.pend_valid = pend_valid;
  assign stat.out_free   = !out_valid || rsp.ready;
endmodule
